// ===== sv/chct_pkg.sv =====
// Package for the chained hash count table.
// Holds field widths, operation and status codes and the count limit.
// No dependencies; every other file of the block imports it.
package chct_pkg;

  // Fixed widths of the beat fields.
  localparam int VALUE_W = 9;
  localparam int COUNT_W = 15;

  // Largest match count; a search saturates here.
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Operation codes carried in func.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // Status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

// ===== sv/chct_req_if.sv =====
// Request channel of the chained hash count table: valid, ready, func, value.
// Depends on chct_pkg for the field widths.
interface chct_req_if import chct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

// ===== sv/chct_rsp_if.sv =====
// Response channel of the chained hash count table: valid, ready, count, status.
// Depends on chct_pkg for the field widths.
interface chct_rsp_if import chct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] match_count;
  logic               status;

  modport source (output valid, output match_count, output status, input ready);
  modport sink   (input valid, input match_count, input status, output ready);
endinterface

// ===== sv/chained_hash_count_table_top.sv =====
// Chained hash count table: top level with sequencer, remainder unit and memories.
// Depends on chct_pkg, chct_req_if and chct_rsp_if.
//
// Each request beat inserts a value or counts the stored copies of it, and
// gives exactly one response beat. The bucket is value modulo BUCKETS: the
// quotient comes from a multiply by a rounded-up reciprocal of BUCKETS in the
// accepting cycle, and the remainder from one multiply and subtract in the
// next. An insert steps through accept, remainder, head/tail read, node
// write, link write and hand-off to the output register; an insert dropped
// on a full pool goes from the head/tail read straight to the hand-off. A
// search steps through accept, remainder, head/tail read and head node
// read, then walks its bucket's chain one node a cycle, a rate set by the
// single read port of the node memory, whose registered next pointer
// addresses the following read, and then hands off. The hand-off waits
// only while an earlier response still sits in the output register with
// rsp.ready low. After reset a clearing pass marks every bucket empty, one
// bucket a cycle, while ready stays low. The output register lets the next
// request be taken while a response waits.
module chained_hash_count_table_top import chct_pkg::*; #(
  parameter int BUCKETS    = 32,
  parameter int POOL_NODES = 16384
) (
  input  logic       clk,
  input  logic       rst,
  chct_req_if.sink   req,
  chct_rsp_if.source rsp
);

  localparam int BW = $clog2(BUCKETS);
  localparam int NW = $clog2(POOL_NODES);
  localparam int PW = NW + 1;
  localparam int DW = VALUE_W + BW + 1;
  localparam logic [PW-1:0] EMPTY     = PW'(POOL_NODES);
  localparam logic [DW-1:0] BUCKETS_D = DW'(BUCKETS);
  localparam logic [BW-1:0] LAST_BKT  = BW'(BUCKETS - 1);

  // Reciprocal of BUCKETS scaled by 2**RSH and rounded up; the quotient it
  // gives is exact for every value of VALUE_W bits.
  localparam int RSH = VALUE_W + BW;
  localparam int MW  = VALUE_W + 2;
  localparam int PRW = VALUE_W + MW;
  localparam logic [MW-1:0] RECIP = MW'(((1 << RSH) + BUCKETS - 1) / BUCKETS);

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_MOD    = 9'b000000100,
    ST_LOOKUP = 9'b000001000,
    ST_INS_WR = 9'b000010000,
    ST_LINK   = 9'b000100000,
    ST_FIRST  = 9'b001000000,
    ST_WALK   = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t state;

  // Memories.
  logic [PW-1:0]      head_mem  [BUCKETS];
  logic [NW-1:0]      tail_mem  [BUCKETS];
  logic [VALUE_W-1:0] val_mem   [POOL_NODES];
  logic [PW-1:0]      next_mem  [POOL_NODES];

  logic [PW-1:0]      head_rd;
  logic [NW-1:0]      tail_rd;
  logic [VALUE_W-1:0] value_rd;
  logic [PW-1:0]      next_rd;

  // Working registers.
  logic               func_q;
  logic [VALUE_W-1:0] value_q;
  logic [VALUE_W-1:0] quot;
  logic [DW-1:0]      rem;
  logic [BW-1:0]      clr_idx;
  logic [PW-1:0]      nodes_used;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] res_count;
  logic               res_status;
  logic               out_valid;
  logic [COUNT_W-1:0] out_count;
  logic               out_status;

  logic [BW-1:0]      bucket;
  logic [PRW-1:0]     prod;
  logic [VALUE_W-1:0] quot_next;
  logic [NW-1:0]      node_raddr;
  logic [NW-1:0]      new_node;
  logic [COUNT_W-1:0] count_next;
  logic               hit;

  assign bucket     = rem[BW-1:0];
  assign prod       = PRW'(req.value) * PRW'(RECIP);
  assign quot_next  = VALUE_W'(prod >> RSH);
  assign new_node   = nodes_used[NW-1:0];
  assign node_raddr = (state == ST_WALK) ? next_rd[NW-1:0] : head_rd[NW-1:0];
  assign hit        = (value_rd == value_q);
  assign count_next = (hit && count != COUNT_MAX) ? count + COUNT_W'(1) : count;

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.match_count = out_count;
  assign rsp.status      = out_status;

  // Bucket head memory: cleared after reset, written on the first insert.
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      head_mem[clr_idx] <= EMPTY;
    end else if (state == ST_LINK && head_rd == EMPTY) begin
      head_mem[bucket] <= nodes_used;
    end
    if (state == ST_LOOKUP) begin
      head_rd <= head_mem[bucket];
    end
  end

  // Bucket tail memory.
  always_ff @(posedge clk) begin
    if (state == ST_LINK) begin
      tail_mem[bucket] <= new_node;
    end
    if (state == ST_LOOKUP) begin
      tail_rd <= tail_mem[bucket];
    end
  end

  // Node value memory.
  always_ff @(posedge clk) begin
    if (state == ST_INS_WR) begin
      val_mem[new_node] <= value_q;
    end
    if (state == ST_FIRST || state == ST_WALK) begin
      value_rd <= val_mem[node_raddr];
    end
  end

  // Node next-pointer memory: new node ends its chain, old tail links to it.
  always_ff @(posedge clk) begin
    if (state == ST_INS_WR) begin
      next_mem[new_node] <= EMPTY;
    end else if (state == ST_LINK && head_rd != EMPTY) begin
      next_mem[tail_rd] <= nodes_used;
    end
    if (state == ST_FIRST || state == ST_WALK) begin
      next_rd <= next_mem[node_raddr];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      nodes_used <= '0;
      out_valid  <= 1'b0;
    end else begin
      // The output register empties when its beat is taken, unless it is
      // reloaded in the same cycle.
      if (out_valid && rsp.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + BW'(1);
          if (clr_idx == LAST_BKT) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            func_q  <= req.func;
            value_q <= req.value;
            quot    <= quot_next;
            state   <= ST_MOD;
          end
        end
        // Remainder from the registered quotient: value minus quotient times BUCKETS.
        ST_MOD: begin
          rem   <= DW'(value_q) - DW'(quot) * BUCKETS_D;
          state <= ST_LOOKUP;
        end
        ST_LOOKUP: begin
          if (func_q == FUNC_INSERT && nodes_used == EMPTY) begin
            res_count  <= '0;
            res_status <= STATUS_FULL;
            state      <= ST_DONE;
          end else if (func_q == FUNC_INSERT) begin
            state <= ST_INS_WR;
          end else begin
            state <= ST_FIRST;
          end
        end
        ST_INS_WR: begin
          state <= ST_LINK;
        end
        ST_LINK: begin
          nodes_used <= nodes_used + PW'(1);
          res_count  <= '0;
          res_status <= STATUS_OK;
          state      <= ST_DONE;
        end
        ST_FIRST: begin
          count <= '0;
          if (head_rd == EMPTY) begin
            res_count  <= '0;
            res_status <= STATUS_OK;
            state      <= ST_DONE;
          end else begin
            state <= ST_WALK;
          end
        end
        // One chain node a cycle; its next pointer addresses the next read.
        ST_WALK: begin
          count <= count_next;
          if (next_rd == EMPTY) begin
            res_count  <= count_next;
            res_status <= STATUS_OK;
            state      <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_count  <= res_count;
            out_status <= res_status;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== dv/chained_hash_count_table_top_tb.sv =====
// Self-checking testbench for chained_hash_count_table_top.
// Depends on chct_pkg, chct_req_if, chct_rsp_if and the block's top level.
// It drives insert and search beats and predicts every reply.
`timescale 1ns / 1ps

module chained_hash_count_table_top_tb;
  import chct_pkg::*;

  localparam int BUCKETS     = 32;
  localparam int POOL_NODES  = 16384;
  localparam int NODE_W      = 15;
  localparam int HOLD_CYCLES = 300;
  localparam logic [NODE_W-1:0] EMPTY_LINK = NODE_W'(POOL_NODES);

  typedef struct packed {
    logic               func;
    logic [VALUE_W-1:0] value;
  } req_beat_t;

  typedef struct packed {
    logic [COUNT_W-1:0] match_count;
    logic               status;
  } rsp_beat_t;

  logic clk;
  logic rst;

  chct_req_if req_ch ();
  chct_rsp_if rsp_ch ();

  chained_hash_count_table_top #(
    .BUCKETS   (BUCKETS),
    .POOL_NODES(POOL_NODES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the chained table.
  logic [NODE_W-1:0]  chain_head [BUCKETS];
  logic [NODE_W-2:0]  chain_tail [BUCKETS];
  logic [VALUE_W-1:0] node_val   [POOL_NODES];
  logic [NODE_W-1:0]  node_link  [POOL_NODES];
  logic [NODE_W-1:0]  nodes_taken;

  req_beat_t request_backlog[$];
  rsp_beat_t pending_replies[$];

  int gap_pct;
  int stall_pct;
  int hold_requests;
  int hold_served;
  int hold_left;
  int mismatches;
  int inserts_sent;
  int searches_sent;
  int refused_seen;
  int top_count_seen;

  req_beat_t next_beat;
  rsp_beat_t want;

  // Applies one beat to the shadow table and returns the reply it must give.
  function automatic rsp_beat_t predict_table_reply(input logic op,
                                                    input logic [VALUE_W-1:0] v);
    rsp_beat_t          r;
    int                 b;
    int                 n;
    int                 steps;
    logic [NODE_W-1:0]  p;
    r.match_count = '0;
    r.status      = STATUS_OK;
    b = int'(v) % BUCKETS;
    if (op == FUNC_INSERT) begin
      if (nodes_taken >= POOL_NODES) begin
        r.status = STATUS_FULL;
      end else begin
        n = int'(nodes_taken);
        node_val[n]  = v;
        node_link[n] = EMPTY_LINK;
        if (chain_head[b] == EMPTY_LINK) begin
          chain_head[b] = NODE_W'(n);
        end else begin
          node_link[chain_tail[b]] = NODE_W'(n);
        end
        chain_tail[b] = (NODE_W-1)'(n);
        nodes_taken   = nodes_taken + 1'b1;
      end
    end else begin
      p     = chain_head[b];
      steps = 0;
      while (p < POOL_NODES && steps < int'(nodes_taken)) begin
        if (node_val[p] == v && r.match_count != COUNT_MAX) begin
          r.match_count = r.match_count + 1'b1;
        end
        p     = node_link[p];
        steps = steps + 1;
      end
    end
    return r;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: offers backlog beats, predicting each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        pending_replies.push_back(predict_table_reply(req_ch.func, req_ch.value));
        if (req_ch.func == FUNC_INSERT) begin
          inserts_sent++;
        end else begin
          searches_sent++;
        end
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
          next_beat = request_backlog.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.func  <= next_beat.func;
          req_ch.value <= next_beat.value;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here and requested by the stimulus.
  always @(posedge clk) begin
    if (rst) begin
      hold_left   <= 0;
      hold_served <= 0;
    end else if (hold_served != hold_requests) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_requests;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks every reply beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_replies.size() == 0) begin
          mismatches++;
          $display("%0t: reply beat with none expected, got count %0d status %0d",
                   $time, rsp_ch.match_count, rsp_ch.status);
        end else begin
          want = pending_replies.pop_front();
          if (rsp_ch.match_count !== want.match_count) begin
            mismatches++;
            $display("%0t: match_count mismatch, expected %0d, got %0d",
                     $time, want.match_count, rsp_ch.match_count);
          end
          if (rsp_ch.status !== want.status) begin
            mismatches++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, rsp_ch.status);
          end
          if (want.status == STATUS_FULL) begin
            refused_seen++;
          end
          if (int'(want.match_count) > top_count_seen) begin
            top_count_seen = int'(want.match_count);
          end
        end
      end
      rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic push_beat(input logic op, input int v);
    req_beat_t it;
    it.func  = op;
    it.value = VALUE_W'(v);
    request_backlog.push_back(it);
  endtask

  // Sets how often the sender idles and the receiver stalls.
  task automatic idle_mode(input int m);
    case (m % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 52; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 52; end
      default: begin gap_pct = 16; stall_pct = 16; end
    endcase
  endtask

  // Random mix, half of it aimed at two hot buckets so chains grow and repeat.
  task automatic queue_random(input int n_items);
    int v;
    repeat (n_items) begin
      if ($urandom_range(1) == 1) begin
        v = ($urandom_range(1) == 1 ? 5 : 26) + 32 * $urandom_range(3);
      end else begin
        v = $urandom_range(511);
      end
      push_beat(($urandom_range(99) < 55) ? FUNC_INSERT : FUNC_SEARCH, v);
    end
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (request_backlog.size() != 0 || req_ch.valid || pending_replies.size() != 0);
  endtask

  // Stimulus.
  initial begin
    int mode;
    rst           = 1'b1;
    req_ch.valid  = 1'b0;
    req_ch.func   = FUNC_INSERT;
    req_ch.value  = '0;
    rsp_ch.ready  = 1'b0;
    gap_pct       = 0;
    stall_pct     = 0;
    hold_requests = 0;
    mismatches    = 0;
    inserts_sent  = 0;
    searches_sent = 0;
    refused_seen  = 0;
    top_count_seen = 0;
    nodes_taken   = '0;
    for (int b = 0; b < BUCKETS; b++) begin
      chain_head[b] = EMPTY_LINK;
      chain_tail[b] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty searches, extremes, collisions in one bucket, repeats.
    @(negedge clk);
    idle_mode(0);
    push_beat(FUNC_SEARCH, 0);
    push_beat(FUNC_SEARCH, 511);
    push_beat(FUNC_INSERT, 0);
    push_beat(FUNC_INSERT, 511);
    push_beat(FUNC_INSERT, 0);
    push_beat(FUNC_INSERT, 32);
    push_beat(FUNC_INSERT, 64);
    push_beat(FUNC_SEARCH, 0);
    push_beat(FUNC_SEARCH, 32);
    push_beat(FUNC_SEARCH, 511);
    push_beat(FUNC_SEARCH, 479);
    push_beat(FUNC_INSERT, 255);
    push_beat(FUNC_SEARCH, 255);
    push_beat(FUNC_SEARCH, 256);
    push_beat(FUNC_INSERT, 511);
    push_beat(FUNC_SEARCH, 511);
    push_beat(FUNC_INSERT, 170);
    push_beat(FUNC_INSERT, 341);
    push_beat(FUNC_SEARCH, 170);
    push_beat(FUNC_SEARCH, 341);
    wait_drained();

    // Random phases, one per idling mode; the first also holds the receiver off.
    for (mode = 0; mode < 4; mode++) begin
      idle_mode(mode);
      queue_random(110);
      if (mode == 0) begin
        hold_requests++;
      end
      wait_drained();
    end

    // Closing mixed phase on the grown chains.
    idle_mode(3);
    queue_random(40);
    wait_drained();

    repeat (60) @(posedge clk);
    $display("Covered %0d inserts (%0d refused on a full pool) and %0d searches.",
             inserts_sent, refused_seen, searches_sent);
    $display("Largest predicted match count: %0d; mismatches: %0d.",
             top_count_seen, mismatches);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("** chained_hash_count_table_top: PASSED **");
    end else begin
      $display("** chained_hash_count_table_top: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #60000000;
    $display("%0t: timeout with %0d replies outstanding", $time, pending_replies.size());
    $display("** chained_hash_count_table_top: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/chct_pkg.sv
sv/chct_req_if.sv
sv/chct_rsp_if.sv
sv/chained_hash_count_table_top.sv
dv/chained_hash_count_table_top_tb.sv
